@@ src/tss_pkg.sv @@
package tss_pkg;

   // Coordinate width; legal range 4 to 16.
   localparam int COORD_BITS = 8;
   localparam int COLOR_BITS = 32;
   localparam int PROD_BITS = 2 * COORD_BITS;
   // Restoring divider: two quotient bits per pipeline stage.
   localparam int DIV_STEPS = 2;
   localparam int DIV_STAGES = (COORD_BITS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_BITS = DIV_STAGES * DIV_STEPS;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } vertex_type;

   typedef struct packed {
      vertex_type a;
      vertex_type b;
      vertex_type c;
      coord_type  row;
      color_type  color;
   } req_type;

   typedef struct packed {
      vertex_type top;
      vertex_type mid;
      vertex_type bot;
      coord_type  row;
      color_type  color;
   } sort_type;

   // One edge after setup: intercept = base +/- (dxmag * t) / dy.
   typedef struct packed {
      coord_type base;
      logic      neg;
      coord_type dxmag;
      coord_type t;
      coord_type dy;
   } edge_type;

   typedef struct packed {
      edge_type  long_e;
      edge_type  short_e;
      logic      in_tri;
      coord_type row;
      color_type color;
   } setup_type;

   typedef struct packed {
      coord_type           base;
      logic                neg;
      coord_type           dvs;
      coord_type           rem;
      logic [DIV_BITS-1:0] dvd;
      logic [DIV_BITS-1:0] quo;
   } div_edge_type;

   typedef struct packed {
      div_edge_type long_e;
      div_edge_type short_e;
      logic         in_tri;
      coord_type    row;
      color_type    color;
   } div_type;

   typedef struct packed {
      coord_type x1;
      coord_type x2;
      logic      in_tri;
      coord_type row;
      color_type color;
   } span_type;

endpackage

@@ src/tss_setup.sv @@
module tss_setup (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tss_pkg::req_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output tss_pkg::div_type  out_data
);
   import tss_pkg::*;

   function automatic edge_type make_edge(vertex_type p, vertex_type q, coord_type row);
      edge_type e;
      e.base  = p.x;
      e.neg   = (q.x < p.x);
      e.dxmag = e.neg ? coord_type'(p.x - q.x) : coord_type'(q.x - p.x);
      e.t     = coord_type'(row - p.y);
      e.dy    = coord_type'(q.y - p.y);
      return e;
   endfunction

   function automatic div_edge_type start_div(edge_type e);
      div_edge_type d;
      logic [PROD_BITS-1:0] num;
      num   = PROD_BITS'(e.dxmag) * PROD_BITS'(e.t);
      d.base = e.base;
      d.neg  = e.neg;
      d.dvs  = e.dy;
      d.rem  = COORD_BITS'(num >> DIV_BITS);
      d.dvd  = DIV_BITS'(num);
      d.quo  = '0;
      return d;
   endfunction

   // Stage 1: sort by y
   logic      sort_valid_ff, sort_valid_in, sort_ready;
   sort_type  sort_ff, sort_in;
   // Stage 2: half select and edge setup
   logic      sel_valid_ff, sel_valid_in, sel_ready;
   setup_type sel_ff, sel_in;
   // Stage 3: numerator product
   logic      mul_valid_ff, mul_valid_in, mul_ready;
   div_type   mul_ff, mul_in;

   vertex_type va, vb, vc, vt;
   logic       upper, lower;

   assign mul_ready  = !mul_valid_ff || out_ready;
   assign sel_ready  = !sel_valid_ff || mul_ready;
   assign sort_ready = !sort_valid_ff || sel_ready;
   assign in_ready   = sort_ready;

   always_comb begin
      va = in_data.a;
      vb = in_data.b;
      vc = in_data.c;
      vt = in_data.a;
      if (va.y > vc.y) begin
         vt = va; va = vc; vc = vt;
      end
      if (va.y > vb.y) begin
         vt = va; va = vb; vb = vt;
      end
      if (vb.y > vc.y) begin
         vt = vb; vb = vc; vc = vt;
      end
      sort_in.top   = va;
      sort_in.mid   = vb;
      sort_in.bot   = vc;
      sort_in.row   = in_data.row;
      sort_in.color = in_data.color;
   end

   always_comb begin
      upper = (sort_ff.top.y != sort_ff.mid.y) && (sort_ff.row >= sort_ff.top.y)
              && (sort_ff.row <= sort_ff.mid.y);
      lower = !upper && (sort_ff.mid.y != sort_ff.bot.y) && (sort_ff.row >= sort_ff.mid.y)
              && (sort_ff.row <= sort_ff.bot.y);
      sel_in.long_e  = make_edge(sort_ff.top, sort_ff.bot, sort_ff.row);
      sel_in.short_e = upper ? make_edge(sort_ff.top, sort_ff.mid, sort_ff.row)
                             : make_edge(sort_ff.mid, sort_ff.bot, sort_ff.row);
      sel_in.in_tri  = upper || lower;
      sel_in.row     = sort_ff.row;
      sel_in.color   = sort_ff.color;
   end

   always_comb begin
      mul_in.long_e  = start_div(sel_ff.long_e);
      mul_in.short_e = start_div(sel_ff.short_e);
      mul_in.in_tri  = sel_ff.in_tri;
      mul_in.row     = sel_ff.row;
      mul_in.color   = sel_ff.color;
   end

   assign sort_valid_in = sort_ready ? in_valid : sort_valid_ff;
   assign sel_valid_in  = sel_ready ? sort_valid_ff : sel_valid_ff;
   assign mul_valid_in  = mul_ready ? sel_valid_ff : mul_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sort_valid_ff <= 1'b0;
         sel_valid_ff  <= 1'b0;
         mul_valid_ff  <= 1'b0;
      end else begin
         sort_valid_ff <= sort_valid_in;
         sel_valid_ff  <= sel_valid_in;
         mul_valid_ff  <= mul_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sort_ready && in_valid) sort_ff <= sort_in;
      if (sel_ready && sort_valid_ff) sel_ff <= sel_in;
      if (mul_ready && sel_valid_ff) mul_ff <= mul_in;
   end

   assign out_valid = mul_valid_ff;
   assign out_data  = mul_ff;

endmodule

@@ src/tss_div_stage.sv @@
module tss_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tss_pkg::div_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output tss_pkg::div_type  out_data
);
   import tss_pkg::*;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   function automatic div_edge_type div_step(div_edge_type e);
      div_edge_type r;
      logic [COORD_BITS:0] trial;
      r     = e;
      trial = {e.rem, e.dvd[DIV_BITS-1]};
      if (trial >= {1'b0, e.dvs}) begin
         r.rem = COORD_BITS'(trial - {1'b0, e.dvs});
         r.quo = {e.quo[DIV_BITS-2:0], 1'b1};
      end else begin
         r.rem = COORD_BITS'(trial);
         r.quo = {e.quo[DIV_BITS-2:0], 1'b0};
      end
      r.dvd = e.dvd << 1;
      return r;
   endfunction

   logic    valid_ff, valid_in;
   div_type data_ff, data_in;

   always_comb begin
      data_in = in_data;
      for (int j = 0; j < DIV_STEPS; j++) begin
         data_in.long_e  = div_step(data_in.long_e);
         data_in.short_e = div_step(data_in.short_e);
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ src/tss_finish.sv @@
module tss_finish (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tss_pkg::div_type     in_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tss_pkg::coord_type   rsp_span_row,
   output tss_pkg::coord_type   rsp_span_start,
   output tss_pkg::coord_type   rsp_span_end,
   output tss_pkg::color_type   rsp_span_color,
   output logic                 rsp_covered
);
   import tss_pkg::*;

   function automatic coord_type intercept(div_edge_type e);
      coord_type q;
      q = coord_type'(e.quo);
      return e.neg ? coord_type'(e.base - q) : coord_type'(e.base + q);
   endfunction

   logic      x_valid_ff, x_valid_in, x_ready;
   span_type  x_ff, x_in;
   logic      o_valid_ff, o_valid_in, o_ready;
   coord_type row_ff, start_ff, end_ff;
   coord_type start_in, end_in;
   color_type color_ff;
   logic      covered_ff, covered_in;

   always_comb begin
      x_in.x1     = intercept(in_data.long_e);
      x_in.x2     = intercept(in_data.short_e);
      x_in.in_tri = in_data.in_tri;
      x_in.row    = in_data.row;
      x_in.color  = in_data.color;
   end

   always_comb begin
      covered_in = x_ff.in_tri && (x_ff.x1 != x_ff.x2);
      if (!covered_in) begin
         start_in = '0;
         end_in   = '0;
      end else if (x_ff.x1 < x_ff.x2) begin
         start_in = x_ff.x1;
         end_in   = x_ff.x2;
      end else begin
         start_in = x_ff.x2;
         end_in   = x_ff.x1;
      end
   end

   assign o_ready    = !o_valid_ff || rsp_ready;
   assign x_ready    = !x_valid_ff || o_ready;
   assign in_ready   = x_ready;
   assign x_valid_in = x_ready ? in_valid : x_valid_ff;
   assign o_valid_in = o_ready ? x_valid_ff : o_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         x_valid_ff <= x_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (x_ready && in_valid) x_ff <= x_in;
      if (o_ready && x_valid_ff) begin
         row_ff     <= x_ff.row;
         color_ff   <= x_ff.color;
         start_ff   <= start_in;
         end_ff     <= end_in;
         covered_ff <= covered_in;
      end
   end

   assign rsp_valid      = o_valid_ff;
   assign rsp_span_row   = row_ff;
   assign rsp_span_start = start_ff;
   assign rsp_span_end   = end_ff;
   assign rsp_span_color = color_ff;
   assign rsp_covered    = covered_ff;

endmodule

@@ src/triangle_scanline_span.sv @@
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  three vertices, query row, fill color
// rsp_      out        rsp_valid / rsp_ready  span row, start, end, color, covered
//
// Takes one request per clock while rsp_ready is high; each request gives one
// response through the setup, restoring-divider (two quotient bits per stage) and
// finish stages. Synchronous active-high reset clears every stage valid bit; data
// regs keep no reset. Every stage has its own valid bit and loads whenever it is
// empty or its successor moves, so bubbles collapse and a stall at rsp_ready backs
// up stage by stage without loss or repeat.
module triangle_scanline_span (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tss_pkg::coord_type  req_vertex_a_x,
   input  tss_pkg::coord_type  req_vertex_a_y,
   input  tss_pkg::coord_type  req_vertex_b_x,
   input  tss_pkg::coord_type  req_vertex_b_y,
   input  tss_pkg::coord_type  req_vertex_c_x,
   input  tss_pkg::coord_type  req_vertex_c_y,
   input  tss_pkg::coord_type  req_query_row,
   input  tss_pkg::color_type  req_fill_color,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tss_pkg::coord_type  rsp_span_row,
   output tss_pkg::coord_type  rsp_span_start,
   output tss_pkg::coord_type  rsp_span_end,
   output tss_pkg::color_type  rsp_span_color,
   output logic                rsp_covered
);
   import tss_pkg::*;

   req_type req_data;

   // Divider chain: index 0 is the setup output, DIV_STAGES the last quotient.
   div_type chain_data  [DIV_STAGES+1];
   logic    chain_valid [DIV_STAGES+1];
   logic    chain_ready [DIV_STAGES+1];

   // Pack the request fields for the setup pipeline
   assign req_data.a.x  = req_vertex_a_x;
   assign req_data.a.y  = req_vertex_a_y;
   assign req_data.b.x  = req_vertex_b_x;
   assign req_data.b.y  = req_vertex_b_y;
   assign req_data.c.x  = req_vertex_c_x;
   assign req_data.c.y  = req_vertex_c_y;
   assign req_data.row  = req_query_row;
   assign req_data.color = req_fill_color;

   // Sort vertices by y, pick the half and edges, form the edge numerators
   tss_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // Divide both edge numerators by their dy, truncating toward zero on
   // magnitudes; the sign is applied afterwards.
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      tss_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // Apply the sign, order the intercepts and hold the response register
   tss_finish u_finish (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (chain_valid[DIV_STAGES]),
      .in_ready       (chain_ready[DIV_STAGES]),
      .in_data        (chain_data[DIV_STAGES]),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_span_row   (rsp_span_row),
      .rsp_span_start (rsp_span_start),
      .rsp_span_end   (rsp_span_end),
      .rsp_span_color (rsp_span_color),
      .rsp_covered    (rsp_covered)
   );

endmodule

@@ src/tss_checker.sv @@
module tss_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input tss_pkg::coord_type  rsp_span_row,
   input tss_pkg::coord_type  rsp_span_start,
   input tss_pkg::coord_type  rsp_span_end,
   input tss_pkg::color_type  rsp_span_color,
   input logic                rsp_covered
);
   import tss_pkg::*;

   // Reset empties the pipeline
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A covered span is non-empty
   a_covered_order : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_covered |-> rsp_span_start < rsp_span_end)
      else $error("covered span with start not below end");

   // An uncovered span reports zero bounds
   a_uncovered_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_covered |-> rsp_span_start == '0 && rsp_span_end == '0)
      else $error("uncovered span with nonzero bounds");

   // A stalled response holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_span_row)
         && $stable(rsp_span_start) && $stable(rsp_span_end)
         && $stable(rsp_span_color) && $stable(rsp_covered))
      else $error("stalled response changed");

   // With the output draining, no stage can block the request side
   a_ready_flow : assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request blocked while response side is ready");

endmodule

bind triangle_scanline_span tss_checker u_checker (.*);

@@ sim/tb_triangle_scanline_span.sv @@
`timescale 1ns / 1ps

module tb_triangle_scanline_span;
   import tss_pkg::*;

   localparam int NUM_RANDOM   = 1530;
   localparam int NUM_DIRECTED = 19;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 300;
   localparam int DRAIN_CYCLES = 20;

   // Triangle shapes for the random part; most keep the row on the triangle.
   typedef enum int {
      SHAPE_FULL,
      SHAPE_SMALL,
      SHAPE_TIE,
      SHAPE_NOISE
   } shape_type;

   // Receiver stall patterns.
   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_MOSTLY,
      READY_PERIODIC
   } stall_mode_type;

   typedef struct packed {
      vertex_type a;
      vertex_type b;
      vertex_type c;
      coord_type  row;
      color_type  color;
   } span_query_type;

   typedef struct packed {
      coord_type span_row;
      coord_type span_start;
      coord_type span_end;
      color_type span_color;
      logic      covered;
   } span_result_type;

   // One directed row; fixed_exp marks a span typed in by hand.
   typedef struct packed {
      coord_type ax, ay, bx, by, cx, cy, row;
      color_type color;
      logic      fixed_exp;
      coord_type span_start;
      coord_type span_end;
      logic      covered;
   } directed_row_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   coord_type req_vertex_a_x, req_vertex_a_y;
   coord_type req_vertex_b_x, req_vertex_b_y;
   coord_type req_vertex_c_x, req_vertex_c_y;
   coord_type req_query_row;
   color_type req_fill_color;
   logic      rsp_valid;
   logic      rsp_ready;
   coord_type rsp_span_row;
   coord_type rsp_span_start;
   coord_type rsp_span_end;
   color_type rsp_span_color;
   logic      rsp_covered;

   span_result_type  expected_spans[$];
   directed_row_type directed_rows[NUM_DIRECTED];
   int               error_count    = 0;
   int               accepted_count = 0;
   int               cycle_count    = 0;

   triangle_scanline_span DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_vertex_a_x (req_vertex_a_x),
      .req_vertex_a_y (req_vertex_a_y),
      .req_vertex_b_x (req_vertex_b_x),
      .req_vertex_b_y (req_vertex_b_y),
      .req_vertex_c_x (req_vertex_c_x),
      .req_vertex_c_y (req_vertex_c_y),
      .req_query_row  (req_query_row),
      .req_fill_color (req_fill_color),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_span_row   (rsp_span_row),
      .rsp_span_start (rsp_span_start),
      .rsp_span_end   (rsp_span_end),
      .rsp_span_color (rsp_span_color),
      .rsp_covered    (rsp_covered)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Intercept of edge p->q at a row; a flat or inverted edge yields p.x.
   // Integer division in SystemVerilog truncates toward zero, as required.
   function automatic int edge_intercept(vertex_type p, vertex_type q, int row);
      int dy;
      dy = int'(q.y) - int'(p.y);
      if (dy <= 0) begin
         return int'(p.x);
      end
      return int'(p.x) + ((int'(q.x) - int'(p.x)) * (row - int'(p.y))) / dy;
   endfunction

   // Compute the span one request covers.
   function automatic span_result_type predict_span(span_query_type q);
      vertex_type      top, mid, bot, tmp;
      int              x_long, x_short, lo, hi, row;
      logic            in_tri;
      span_result_type r;
      top = q.a;
      mid = q.b;
      bot = q.c;
      // Three compare-swaps on whole vertices, swapping only on strictly greater y.
      if (top.y > bot.y) begin
         tmp = top; top = bot; bot = tmp;
      end
      if (top.y > mid.y) begin
         tmp = top; top = mid; mid = tmp;
      end
      if (mid.y > bot.y) begin
         tmp = mid; mid = bot; bot = tmp;
      end
      row     = int'(q.row);
      in_tri  = 1'b0;
      x_long  = 0;
      x_short = 0;
      if (top.y != mid.y && q.row >= top.y && q.row <= mid.y) begin
         in_tri  = 1'b1;
         x_long  = edge_intercept(top, bot, row);
         x_short = edge_intercept(top, mid, row);
      end else if (mid.y != bot.y && q.row >= mid.y && q.row <= bot.y) begin
         in_tri  = 1'b1;
         x_long  = edge_intercept(top, bot, row);
         x_short = edge_intercept(mid, bot, row);
      end
      lo = (x_long < x_short) ? x_long : x_short;
      hi = (x_long < x_short) ? x_short : x_long;
      r.span_row   = q.row;
      r.span_color = q.color;
      if (in_tri && lo < hi) begin
         r.span_start = coord_type'(lo);
         r.span_end   = coord_type'(hi);
         r.covered    = 1'b1;
      end else begin
         r.span_start = '0;
         r.span_end   = '0;
         r.covered    = 1'b0;
      end
      return r;
   endfunction

   // Draw one random triangle query.
   function automatic span_query_type random_query();
      span_query_type q;
      shape_type      shape;
      int             pick, base_x, base_y, miny, maxy;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         shape = SHAPE_FULL;
      end else if (pick < 75) begin
         shape = SHAPE_SMALL;
      end else if (pick < 85) begin
         shape = SHAPE_TIE;
      end else begin
         shape = SHAPE_NOISE;
      end
      q.a.x   = coord_type'($urandom);
      q.a.y   = coord_type'($urandom);
      q.b.x   = coord_type'($urandom);
      q.b.y   = coord_type'($urandom);
      q.c.x   = coord_type'($urandom);
      q.c.y   = coord_type'($urandom);
      q.row   = coord_type'($urandom);
      q.color = color_type'($urandom);
      case (shape)
         SHAPE_SMALL: begin
            // Keep all corners within a 17-pixel window so spans stay narrow.
            base_x = $urandom_range(0, 239);
            base_y = $urandom_range(0, 239);
            q.a.x  = coord_type'(base_x + $urandom_range(0, 16));
            q.a.y  = coord_type'(base_y + $urandom_range(0, 16));
            q.b.x  = coord_type'(base_x + $urandom_range(0, 16));
            q.b.y  = coord_type'(base_y + $urandom_range(0, 16));
            q.c.x  = coord_type'(base_x + $urandom_range(0, 16));
            q.c.y  = coord_type'(base_y + $urandom_range(0, 16));
         end
         SHAPE_TIE: begin
            // Share one y between two corners to hit flat tops and bottoms.
            case ($urandom_range(0, 2))
               0: q.b.y = q.a.y;
               1: q.c.y = q.a.y;
               default: q.c.y = q.b.y;
            endcase
         end
         default: begin
         end
      endcase
      if (shape != SHAPE_NOISE) begin
         miny = q.a.y;
         maxy = q.a.y;
         if (q.b.y < miny) miny = q.b.y;
         if (q.c.y < miny) miny = q.c.y;
         if (q.b.y > maxy) maxy = q.b.y;
         if (q.c.y > maxy) maxy = q.c.y;
         q.row = coord_type'($urandom_range(maxy, miny));
      end
      return q;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h, expected %0h at cycle %0d",
               what, got, want, cycle_count);
      error_count++;
   endtask

   // Offer one request and hold it until the handshake completes.
   task automatic send_request(input span_query_type q);
      req_valid      <= 1'b1;
      req_vertex_a_x <= q.a.x;
      req_vertex_a_y <= q.a.y;
      req_vertex_b_x <= q.b.x;
      req_vertex_b_y <= q.b.y;
      req_vertex_c_x <= q.c.x;
      req_vertex_c_y <= q.c.y;
      req_query_row  <= q.row;
      req_fill_color <= q.color;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accepted_count++;
   endtask

   // Free-running cycle counter; bail out if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Response checker: sample pre-edge values and compare against the oldest span.
   always @(posedge clock) begin
      span_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_spans.size() == 0) begin
            report_mismatch("unexpected response row", 32'(rsp_span_row), 32'hFFFF_FFFF);
         end else begin
            want = expected_spans.pop_front();
            if (rsp_span_row !== want.span_row)
               report_mismatch("span_row", 32'(rsp_span_row), 32'(want.span_row));
            if (rsp_span_start !== want.span_start)
               report_mismatch("span_start", 32'(rsp_span_start), 32'(want.span_start));
            if (rsp_span_end !== want.span_end)
               report_mismatch("span_end", 32'(rsp_span_end), 32'(want.span_end));
            if (rsp_span_color !== want.span_color)
               report_mismatch("span_color", rsp_span_color, want.span_color);
            if (rsp_covered !== want.covered)
               report_mismatch("covered", 32'(rsp_covered), 32'(want.covered));
         end
      end
   end

   // Receiver: switch between stall patterns; once, hold off long enough to
   // back the pipeline up into the request port.
   initial begin
      stall_mode_type mode;
      int             seg_len, i;
      bit             hold_done;
      hold_done = 1'b0;
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (!hold_done && accepted_count >= HOLD_AFTER) begin
            hold_done = 1'b1;
            for (i = 0; i < HOLD_CYCLES; i++) begin
               @(posedge clock);
               rsp_ready <= 1'b0;
            end
         end
         mode    = stall_mode_type'($urandom_range(0, 3));
         seg_len = $urandom_range(20, 200);
         for (i = 0; i < seg_len; i++) begin
            @(posedge clock);
            case (mode)
               READY_ALWAYS:   rsp_ready <= 1'b1;
               READY_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
               READY_MOSTLY:   rsp_ready <= ($urandom_range(0, 4) != 0);
               READY_PERIODIC: rsp_ready <= (i % 3 == 0);
               default:        rsp_ready <= 1'b1;
            endcase
         end
      end
   end

   // Main sequence: reset, directed table, random bursts, drain, verdict.
   initial begin
      span_query_type   q;
      span_result_type  want;
      directed_row_type d;
      int               item_idx, total, burst, gap;

      // Directed table: ax ay bx by cx cy row color, then a hand-typed span
      // where one is obvious (start, end, covered); other rows use the predictor.
      directed_rows = '{
         // flat triangle, all y equal: nothing covered
         '{8'd10,  8'd50,  8'd100, 8'd50,  8'd200, 8'd50,  8'd50,  32'hFFFF_FFFF,
           1'b1, 8'd0, 8'd0, 1'b0},
         // row above the triangle
         '{8'd10,  8'd20,  8'd100, 8'd60,  8'd50,  8'd100, 8'd5,   32'h0000_0000,
           1'b1, 8'd0, 8'd0, 1'b0},
         // row below the triangle
         '{8'd10,  8'd20,  8'd100, 8'd60,  8'd50,  8'd100, 8'd200, 32'h1234_5678,
           1'b1, 8'd0, 8'd0, 1'b0},
         // full-width flat top edge
         '{8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   32'h8000_0001,
           1'b1, 8'd0, 8'd255, 1'b1},
         // same triangle at its apex: zero-width span
         '{8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd255, 32'h7FFF_FFFE,
           1'b1, 8'd0, 8'd0, 1'b0},
         // all corners at the maximum
         '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF,
           1'b1, 8'd0, 8'd0, 1'b0},
         // all corners at zero
         '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   32'h0000_0000,
           1'b1, 8'd0, 8'd0, 1'b0},
         // collinear corners: zero-width span
         '{8'd0,   8'd0,   8'd128, 8'd128, 8'd255, 8'd255, 8'd64,  32'hA5A5_5A5A,
           1'b1, 8'd0, 8'd0, 1'b0},
         // full-width bottom reached through the upper half
         '{8'd0,   8'd0,   8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 32'h5A5A_A5A5,
           1'b1, 8'd0, 8'd255, 1'b1},
         // single top corner on the row: zero-width span
         '{8'd128, 8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd0,   32'hDEAD_BEEF,
           1'b1, 8'd0, 8'd0, 1'b0},
         // unsorted input order
         '{8'd0,   8'd255, 8'd255, 8'd0,   8'd128, 8'd128, 8'd128, 32'h0F0F_0F0F,
           1'b0, 8'd0, 8'd0, 1'b0},
         // upper half
         '{8'd100, 8'd10,  8'd20,  8'd90,  8'd200, 8'd200, 8'd50,  32'hF0F0_F0F0,
           1'b0, 8'd0, 8'd0, 1'b0},
         // lower half
         '{8'd100, 8'd10,  8'd20,  8'd90,  8'd200, 8'd200, 8'd150, 32'h3333_CCCC,
           1'b0, 8'd0, 8'd0, 1'b0},
         // row on the middle corner, where both halves meet
         '{8'd100, 8'd10,  8'd20,  8'd90,  8'd200, 8'd200, 8'd90,  32'hCCCC_3333,
           1'b0, 8'd0, 8'd0, 1'b0},
         // negative slopes: truncation toward zero
         '{8'd200, 8'd0,   8'd0,   8'd100, 8'd50,  8'd255, 8'd30,  32'h0102_0304,
           1'b0, 8'd0, 8'd0, 1'b0},
         // flat top: only the lower half applies
         '{8'd50,  8'd0,   8'd150, 8'd0,   8'd100, 8'd255, 8'd128, 32'h0504_0302,
           1'b0, 8'd0, 8'd0, 1'b0},
         // flat bottom, row on the bottom edge
         '{8'd100, 8'd0,   8'd30,  8'd200, 8'd220, 8'd200, 8'd200, 32'hAAAA_5555,
           1'b0, 8'd0, 8'd0, 1'b0},
         // vertical long edge
         '{8'd10,  8'd0,   8'd10,  8'd255, 8'd255, 8'd128, 8'd64,  32'h5555_AAAA,
           1'b0, 8'd0, 8'd0, 1'b0},
         // row on the top corner with equal-y tie in the sort
         '{8'd250, 8'd7,   8'd3,   8'd7,   8'd128, 8'd250, 8'd7,   32'hC0FF_EE00,
           1'b0, 8'd0, 8'd0, 1'b0}
      };

      // Drive every input to a known value before the first edge.
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_vertex_a_x <= '0;
      req_vertex_a_y <= '0;
      req_vertex_b_x <= '0;
      req_vertex_b_y <= '0;
      req_vertex_c_x <= '0;
      req_vertex_c_y <= '0;
      req_query_row  <= '0;
      req_fill_color <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Send in bursts of random length; gaps between bursts are random and
      // sometimes zero so valid stays high across the boundary.
      total    = NUM_DIRECTED + NUM_RANDOM;
      item_idx = 0;
      while (item_idx < total) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && item_idx < total) begin
            if (item_idx < NUM_DIRECTED) begin
               d       = directed_rows[item_idx];
               q.a.x   = d.ax;
               q.a.y   = d.ay;
               q.b.x   = d.bx;
               q.b.y   = d.by;
               q.c.x   = d.cx;
               q.c.y   = d.cy;
               q.row   = d.row;
               q.color = d.color;
               if (d.fixed_exp) begin
                  want.span_row   = d.row;
                  want.span_start = d.span_start;
                  want.span_end   = d.span_end;
                  want.span_color = d.color;
                  want.covered    = d.covered;
               end else begin
                  want = predict_span(q);
               end
            end else begin
               q    = random_query();
               want = predict_span(q);
            end
            send_request(q);
            // Queue the span at the accepting edge; it cannot return the same cycle.
            expected_spans.push_back(want);
            item_idx++;
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0 || item_idx >= total) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      // Drain: wait for every outstanding span, then watch for strays.
      while (expected_spans.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
